/* hw/rtl/rotation_matrix_to_quaternion_macros.svh */
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
// Self-contained; included by the files that carry assertions.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define RMQ_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rmq_pkg.sv */
// Package for the rotation-matrix-to-quaternion block: widths, constants and types.
// No dependencies; imported by every module of the block.
package rmq_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // Unnormalised components stay below 2^(ELEM_WIDTH+1) in magnitude.
    localparam int Q_W   = ELEM_WIDTH + 2;
    localparam int A_W   = ELEM_WIDTH + 1;
    localparam int SQ_W  = 2 * A_W;
    localparam int S_W   = SQ_W + 2;
    // Quotient of a^2 * 2^(2F+2) / s never exceeds 2^(2F+2).
    localparam int QB    = 2 * FRAC_BITS + 3;
    localparam int DW    = QB + 1;
    localparam int RB    = DW / 2;
    localparam int RW    = RB + 4;
    localparam int OUT_W = FRAC_BITS + 2;
    localparam int LANES = 4;
    localparam int LATENCY = 4 + QB + RB + 1;

    localparam logic signed [Q_W-1:0]   ONE_Q   = Q_W'(1 << FRAC_BITS);
    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] m00;
        logic signed [ELEM_WIDTH-1:0] m01;
        logic signed [ELEM_WIDTH-1:0] m02;
        logic signed [ELEM_WIDTH-1:0] m10;
        logic signed [ELEM_WIDTH-1:0] m11;
        logic signed [ELEM_WIDTH-1:0] m12;
        logic signed [ELEM_WIDTH-1:0] m20;
        logic signed [ELEM_WIDTH-1:0] m21;
        logic signed [ELEM_WIDTH-1:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic signed [OUT_W-1:0] quat_w;
    } t_quat;

    // Per-lane control that travels alongside the data.
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } t_ctl;

endpackage

/* hw/rtl/rmq_front.sv */
// Front end: branch choice, unnormalised quaternion, squares and squared length.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_mat                          i_mat,
    output t_ctl [LANES-1:0]              o_ctl,
    output logic [LANES-1:0][SQ_W-1:0]    o_sq,
    output logic [S_W-1:0]                o_sum
);

    logic                   r_v1, r_v2, r_v3, r_v4;
    t_mat                   r_mat;
    logic signed [Q_W-1:0]  r_q [LANES];
    logic signed [Q_W-1:0]  n_q [LANES];
    logic [SQ_W-1:0]        r_sq3 [LANES];
    logic [SQ_W-1:0]        n_sq [LANES];
    logic [LANES-1:0]       r_neg3, r_neg4, n_neg;
    logic [LANES-1:0][SQ_W-1:0] r_sq4;
    logic [S_W-1:0]         r_sum, n_sum;
    logic [A_W-1:0]         c_mag [LANES];

    logic signed [Q_W-1:0]  e00, e01, e02, e10, e11, e12, e20, e21, e22, c_trace;

    always_comb begin
        e00 = Q_W'(r_mat.m00);
        e01 = Q_W'(r_mat.m01);
        e02 = Q_W'(r_mat.m02);
        e10 = Q_W'(r_mat.m10);
        e11 = Q_W'(r_mat.m11);
        e12 = Q_W'(r_mat.m12);
        e20 = Q_W'(r_mat.m20);
        e21 = Q_W'(r_mat.m21);
        e22 = Q_W'(r_mat.m22);
        c_trace = e00 + e11 + e22;
        if (c_trace >= Q_W'(1)) begin
            n_q[0] = e21 - e12;
            n_q[1] = e02 - e20;
            n_q[2] = e10 - e01;
            n_q[3] = c_trace + ONE_Q;
        end else if (e00 > e11 && e00 > e22) begin
            n_q[0] = ONE_Q + e00 - e11 - e22;
            n_q[1] = e10 + e01;
            n_q[2] = e02 + e20;
            n_q[3] = e21 - e12;
        end else if (e11 > e22) begin
            n_q[0] = e01 + e10;
            n_q[1] = ONE_Q + e11 - e00 - e22;
            n_q[2] = e21 + e12;
            n_q[3] = e02 - e20;
        end else begin
            n_q[0] = e02 + e20;
            n_q[1] = e21 + e12;
            n_q[2] = ONE_Q + e22 - e00 - e11;
            n_q[3] = e10 - e01;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_neg[i] = r_q[i][Q_W-1];
            c_mag[i] = n_neg[i] ? A_W'(-r_q[i]) : A_W'(r_q[i]);
            n_sq[i]  = SQ_W'(c_mag[i]) * SQ_W'(c_mag[i]);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            n_sum = n_sum + S_W'(r_sq3[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mat  <= i_mat;
        r_q    <= n_q;
        r_sq3  <= n_sq;
        r_neg3 <= n_neg;
        for (int i = 0; i < LANES; i++) begin
            r_sq4[i] <= r_sq3[i];
        end
        r_neg4 <= r_neg3;
        r_sum  <= n_sum;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            o_ctl[i].valid = r_v4;
            o_ctl[i].neg   = r_neg4[i];
            o_ctl[i].zero  = (r_sum == '0);
        end
    end

    assign o_sq  = r_sq4;
    assign o_sum = r_sum;

endmodule

/* hw/rtl/rmq_div.sv */
// Restoring divider, one quotient bit per stage: floor(a^2 * 2^(2F+2) / s).
// Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl            i_ctl,
    input  logic [SQ_W-1:0] i_sq,
    input  logic [S_W-1:0]  i_sum,
    output t_ctl            o_ctl,
    output logic [QB-1:0]   o_quo
);

    logic [S_W-1:0] r_rem [QB];
    logic [QB-1:0]  r_quo [QB];
    logic [S_W-1:0] r_div [QB];
    t_ctl           r_ctl [QB];

    logic [S_W-1:0] s_rem [QB];
    logic [QB-1:0]  s_quo [QB];
    logic [S_W-1:0] s_div [QB];
    t_ctl           s_ctl [QB];
    logic           s_bit [QB];

    logic [S_W:0]   c_trial [QB];
    logic [S_W-1:0] n_rem [QB];
    logic [QB-1:0]  n_quo [QB];

    // The top bits of the dividend start as the remainder; only the lowest bit
    // of a^2 is shifted in afterwards, followed by zeros.
    always_comb begin
        s_rem[0] = S_W'(i_sq >> 1);
        s_bit[0] = i_sq[0];
        s_quo[0] = '0;
        s_div[0] = i_sum;
        s_ctl[0] = i_ctl;
        for (int k = 1; k < QB; k++) begin
            s_rem[k] = r_rem[k-1];
            s_bit[k] = 1'b0;
            s_quo[k] = r_quo[k-1];
            s_div[k] = r_div[k-1];
            s_ctl[k] = r_ctl[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            c_trial[k] = {s_rem[k], s_bit[k]};
            if (c_trial[k] >= {1'b0, s_div[k]}) begin
                n_rem[k] = S_W'(c_trial[k] - {1'b0, s_div[k]});
                n_quo[k] = {s_quo[k][QB-2:0], 1'b1};
            end else begin
                n_rem[k] = c_trial[k][S_W-1:0];
                n_quo[k] = {s_quo[k][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
            r_div[k] <= s_div[k];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            for (int k = 0; k < QB; k++) begin
                r_ctl[k] <= s_ctl[k];
            end
        end
    end

    assign o_ctl = r_ctl[QB-1];
    assign o_quo = r_quo[QB-1];

endmodule

/* hw/rtl/rmq_sqrt.sv */
// Integer square root, one root bit per stage, then rounding and sign.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [QB-1:0]           i_rad,
    output t_ctl                    o_ctl,
    output logic signed [OUT_W-1:0] o_val
);

    logic [DW-1:0] r_rad [RB];
    logic [RW-1:0] r_rem [RB];
    logic [RB-1:0] r_root [RB];
    t_ctl          r_ctl [RB];

    logic [DW-1:0] s_rad [RB];
    logic [RW-1:0] s_rem [RB];
    logic [RB-1:0] s_root [RB];
    t_ctl          s_ctl [RB];

    logic [RW-1:0] c_sh [RB];
    logic [RW-1:0] c_trial [RB];
    logic [RW-1:0] n_rem [RB];
    logic [RB-1:0] n_root [RB];

    logic [RB:0]             c_inc;
    logic [OUT_W-1:0]        c_mag;
    logic signed [OUT_W-1:0] r_val, n_val;
    t_ctl                    r_octl;

    always_comb begin
        s_rad[0]  = DW'(i_rad);
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_ctl[0]  = i_ctl;
        for (int k = 1; k < RB; k++) begin
            s_rad[k]  = r_rad[k-1];
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_ctl[k]  = r_ctl[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < RB; k++) begin
            c_sh[k]    = {s_rem[k][RW-3:0], s_rad[k][DW-1:DW-2]};
            c_trial[k] = RW'({s_root[k], 2'b01});
            if (c_sh[k] >= c_trial[k]) begin
                n_rem[k]  = c_sh[k] - c_trial[k];
                n_root[k] = {s_root[k][RB-2:0], 1'b1};
            end else begin
                n_rem[k]  = c_sh[k];
                n_root[k] = {s_root[k][RB-2:0], 1'b0};
            end
        end
    end

    // The largest r with (2r-1)^2 within the quotient is half the root, rounded up.
    always_comb begin
        c_inc = (RB+1)'(r_root[RB-1]) + (RB+1)'(1);
        c_mag = OUT_W'(c_inc[RB:1]);
        if (r_ctl[RB-1].zero) begin
            n_val = '0;
        end else if (r_ctl[RB-1].neg) begin
            n_val = -$signed(c_mag);
        end else begin
            n_val = $signed(c_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RB; k++) begin
            r_rad[k]  <= s_rad[k] << 2;
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
        r_val <= n_val;
        if (!i_rst_n) begin
            for (int k = 0; k < RB; k++) begin
                r_ctl[k] <= '0;
            end
            r_octl <= '0;
        end else begin
            for (int k = 0; k < RB; k++) begin
                r_ctl[k] <= s_ctl[k];
            end
            r_octl <= r_ctl[RB-1];
        end
    end

    assign o_ctl = r_octl;
    assign o_val = r_val;

endmodule

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, fully pipelined: one matrix per cycle while not
// busy. From start to o_strobe: four front stages, one divider stage per quotient bit
// (31), one root stage per root bit (16) and an output register. Synchronous active-low
// reset empties the pipeline; busy is high during reset and until a reset-done flag
// register sets after it. Results cannot be stalled. Depends on rmq_pkg and submodules.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_mat  i_mat,
    output logic  o_strobe,
    output t_quat o_quat
);

    logic                       r_rst_done;
    t_ctl [LANES-1:0]           front_ctl;
    logic [LANES-1:0][SQ_W-1:0] front_sq;
    logic [S_W-1:0]             front_sum;
    t_ctl                       div_ctl [LANES];
    logic [QB-1:0]              div_quo [LANES];
    t_ctl                       sq_ctl [LANES];
    logic signed [OUT_W-1:0]    sq_val [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_done <= 1'b0;
        end else begin
            r_rst_done <= 1'b1;
        end
    end

    assign busy = !r_rst_done;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_mat   (i_mat),
        .o_ctl   (front_ctl),
        .o_sq    (front_sq),
        .o_sum   (front_sum)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rmq_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (front_ctl[g]),
            .i_sq    (front_sq[g]),
            .i_sum   (front_sum),
            .o_ctl   (div_ctl[g]),
            .o_quo   (div_quo[g])
        );

        rmq_sqrt u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (div_ctl[g]),
            .i_rad   (div_quo[g]),
            .o_ctl   (sq_ctl[g]),
            .o_val   (sq_val[g])
        );
    end

    assign o_strobe      = sq_ctl[0].valid;
    assign o_quat.quat_x = sq_val[0];
    assign o_quat.quat_y = sq_val[1];
    assign o_quat.quat_z = sq_val[2];
    assign o_quat.quat_w = sq_val[3];

    `RMQ_ASSERT_IMP(a_unit_range, i_clk, i_rst_n, o_strobe,
        o_quat.quat_x <= ONE_OUT && o_quat.quat_x >= -ONE_OUT &&
        o_quat.quat_y <= ONE_OUT && o_quat.quat_y >= -ONE_OUT &&
        o_quat.quat_z <= ONE_OUT && o_quat.quat_z >= -ONE_OUT &&
        o_quat.quat_w <= ONE_OUT && o_quat.quat_w >= -ONE_OUT,
        "quaternion component outside unit range")
    `RMQ_ASSERT_IMP(a_nonzero, i_clk, i_rst_n, o_strobe,
        o_quat.quat_x != '0 || o_quat.quat_y != '0 ||
        o_quat.quat_z != '0 || o_quat.quat_w != '0,
        "all quaternion components are zero")
    `RMQ_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, busy && !o_strobe,
        "pipeline not emptied by reset")

endmodule
